// ----- sv/utf8_text_line_splitter_core_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-8 text line splitter assertion macros
// Shared concurrent property checks on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_LINE_SPLITTER_CORE_MACROS_SVH
`define UTF8_TEXT_LINE_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication
`define UTF8LS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define UTF8LS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/utf8ls_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8ls_pkg
// Types and constants shared by the UTF-8 text line splitter modules.
// ----------------------------------------------------------------------------
package utf8ls_pkg;

    localparam int TAB_WIDTH = 8;
    localparam int SPACE_W   = $clog2(TAB_WIDTH + 1);
    localparam int CP_W      = 31;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CP_W-1:0]   CP_VT    = 31'h0000_000B;
    localparam logic [CP_W-1:0]   CP_FF    = 31'h0000_000C;
    localparam logic [CP_W-1:0]   CP_NEL   = 31'h0000_0085;
    localparam logic [CP_W-1:0]   CP_LSEP  = 31'h0000_2028;
    localparam logic [CP_W-1:0]   CP_PSEP  = 31'h0000_2029;
    localparam logic [CP_W-1:0]   CP_SPACE = 31'h0000_0020;

    // Results still owed for one accepted byte, in emission order:
    // held CR line end, decoded code, tab spaces, text end.
    typedef struct packed {
        logic               cr_le;
        logic               code_vld;
        logic               code_le;
        logic [CP_W-1:0]    code_point;
        logic [SPACE_W-1:0] space_cnt;
        logic               fin;
    } plan_t;

    function automatic logic is_line_term(input logic [CP_W-1:0] cp);
        return (cp == CP_W'(CH_LF)) || (cp == CP_VT) || (cp == CP_FF) ||
               (cp == CP_W'(CH_CR)) || (cp == CP_NEL) || (cp == CP_LSEP) ||
               (cp == CP_PSEP);
    endfunction

endpackage

// ----- sv/utf8ls_decode.sv -----
// ----------------------------------------------------------------------------
// utf8ls_decode
// Byte-level UTF-8 decoder state plus CR/LF folding and tab expansion plan.
// ----------------------------------------------------------------------------
`include "utf8_text_line_splitter_core_macros.svh"

module utf8ls_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_en,
    input  logic [utf8ls_pkg::BYTE_W-1:0]       text_byte,
    input  logic                                final_byte,
    output utf8ls_pkg::plan_t                   plan_o
);

    logic                           held_cr_reg, held_cr_next;
    logic [2:0]                     cont_left_reg, cont_left_next;
    logic [utf8ls_pkg::CP_W-1:0]    partial_reg, partial_next;

    logic [2:0]                     cont_a;
    logic [utf8ls_pkg::CP_W-1:0]    part_a;
    logic [utf8ls_pkg::CP_W-1:0]    cont_bits;
    logic [utf8ls_pkg::CP_W-1:0]    code;
    logic                           code_vld;

    always_comb begin
        plan_o       = '0;
        held_cr_next = 1'b0;
        code         = '0;
        code_vld     = 1'b0;
        cont_bits    = '0;
        cont_a       = cont_left_reg;
        part_a       = partial_reg;

        // Release a held CR unless this byte is the LF that completes CR LF; with a sequence open, drop it and the CR
        if (held_cr_reg && (text_byte != utf8ls_pkg::CH_LF)) begin
            if (cont_left_reg != 3'd0) begin
                cont_a = 3'd0;
                part_a = '0;
            end else begin
                plan_o.cr_le = 1'b1;
            end
        end

        cont_left_next = cont_a;
        partial_next   = part_a;

        if ((text_byte == utf8ls_pkg::CH_CR) && !final_byte) begin
            held_cr_next = 1'b1;
        end else if (text_byte == utf8ls_pkg::CH_TAB) begin
            // first space breaks an open sequence and is dropped
            if (cont_a != 3'd0) begin
                plan_o.space_cnt = utf8ls_pkg::SPACE_W'(utf8ls_pkg::TAB_WIDTH - 1);
            end else begin
                plan_o.space_cnt = utf8ls_pkg::SPACE_W'(utf8ls_pkg::TAB_WIDTH);
            end
            cont_left_next = 3'd0;
            partial_next   = '0;
        end else if (cont_a != 3'd0) begin
            if (text_byte[7:6] == 2'b10) begin
                cont_left_next = cont_a - 3'd1;
                case (cont_left_next)
                    3'd0:    cont_bits = utf8ls_pkg::CP_W'(text_byte[5:0]);
                    3'd1:    cont_bits = utf8ls_pkg::CP_W'(text_byte[5:0]) << 6;
                    3'd2:    cont_bits = utf8ls_pkg::CP_W'(text_byte[5:0]) << 12;
                    3'd3:    cont_bits = utf8ls_pkg::CP_W'(text_byte[5:0]) << 18;
                    default: cont_bits = utf8ls_pkg::CP_W'(text_byte[5:0]) << 24;
                endcase
                partial_next = part_a | cont_bits;
                if (cont_left_next == 3'd0) begin
                    code_vld     = 1'b1;
                    code         = partial_next;
                    partial_next = '0;
                end
            end else begin
                // drop the breaking byte with the open sequence
                cont_left_next = 3'd0;
                partial_next   = '0;
            end
        end else begin
            casez (text_byte)
                8'b0???????: begin
                    code_vld = 1'b1;
                    code     = utf8ls_pkg::CP_W'(text_byte);
                end
                8'b110?????: begin
                    cont_left_next = 3'd1;
                    partial_next   = utf8ls_pkg::CP_W'(text_byte[4:0]) << 6;
                end
                8'b1110????: begin
                    cont_left_next = 3'd2;
                    partial_next   = utf8ls_pkg::CP_W'(text_byte[3:0]) << 12;
                end
                8'b11110???: begin
                    cont_left_next = 3'd3;
                    partial_next   = utf8ls_pkg::CP_W'(text_byte[2:0]) << 18;
                end
                8'b111110??: begin
                    cont_left_next = 3'd4;
                    partial_next   = utf8ls_pkg::CP_W'(text_byte[1:0]) << 24;
                end
                8'b1111110?: begin
                    cont_left_next = 3'd5;
                    partial_next   = utf8ls_pkg::CP_W'(text_byte[0]) << 30;
                end
                default: begin
                    // lone continuation, 0xFE, 0xFF: drop
                end
            endcase
        end

        if (final_byte) begin
            cont_left_next = 3'd0;
            partial_next   = '0;
            held_cr_next   = 1'b0;
            plan_o.fin     = 1'b1;
        end

        plan_o.code_vld = code_vld;
        if (code_vld && utf8ls_pkg::is_line_term(code)) begin
            plan_o.code_le    = 1'b1;
            plan_o.code_point = '0;
        end else begin
            plan_o.code_point = code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cr_reg   <= 1'b0;
            cont_left_reg <= 3'd0;
            partial_reg   <= '0;
        end else if (in_en) begin
            held_cr_reg   <= held_cr_next;
            cont_left_reg <= cont_left_next;
            partial_reg   <= partial_next;
        end
    end

    `UTF8LS_ASSERT_NEXT(a_final_clears, in_en && final_byte, (cont_left_reg == 3'd0) && !held_cr_reg, "state not cleared after final byte")
    `UTF8LS_ASSERT_NEXT(a_cr_held, in_en && (text_byte == utf8ls_pkg::CH_CR) && !final_byte, held_cr_reg, "CR not held")
    `UTF8LS_ASSERT_NOW(a_cont_range, 1'b1, cont_left_reg <= 3'd5, "continuation count out of range")

endmodule

// ----- sv/utf8_text_line_splitter_core.sv -----
// ----------------------------------------------------------------------------
// utf8_text_line_splitter_core
// UTF-8 text bytes in, decoded code points and line ends out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per transfer in s_tdata[7:0]; s_tlast marks
//   the final byte of a text. m_ channel: one result per transfer, code
//   point in m_tdata[30:0], m_tuser[0] line end, m_tuser[1] text end,
//   m_tlast on the last result caused by one input byte.
//   A byte is decoded as it is accepted into a plan register that holds its
//   pending results (held CR line end, code or tab spaces, text end); the
//   emitter moves one result per cycle into the output register while the
//   output register is empty or m_tready is high. The first result of a
//   byte passes through the plan register, then the output register.
//   Throughput: 1 byte per cycle while each byte gives at most one result
//   and the output is not stalled; a byte giving several results (up to
//   10 for a tab after a held CR on the final byte) holds the emitter, and
//   s_tready stays low until its last result moves into the output
//   register. Bytes that give no result leave the plan empty.
//   Reset clears the decoder state, the plan and the output valid.
//   When m_tready is low the output register holds its result and the plan
//   stalls; s_tready drops once the plan holds undelivered results.
// ----------------------------------------------------------------------------
`include "utf8_text_line_splitter_core_macros.svh"

module utf8_text_line_splitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
    output logic [1:0]  m_tuser,   // [0] line_end, [1] text_end
    output logic        m_tlast    // last_of_run
);

    utf8ls_pkg::plan_t              plan_in;
    utf8ls_pkg::plan_t              plan_reg, plan_next, plan_after;

    logic                           m_tvalid_reg;
    logic [utf8ls_pkg::CP_W-1:0]    m_code_reg, m_code_next;
    logic                           m_le_reg, m_le_next;
    logic                           m_te_reg, m_te_next;
    logic                           m_last_reg, m_last_next;

    logic                           plan_any;
    logic                           plan_last;
    logic                           emit_en;
    logic                           s_accept;

    utf8ls_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_en      (s_accept),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .plan_o     (plan_in)
    );

    assign plan_any = plan_reg.cr_le || plan_reg.code_vld ||
                      (plan_reg.space_cnt != '0) || plan_reg.fin;

    // Pick the first pending result and drop it from the plan
    always_comb begin
        plan_after  = plan_reg;
        m_code_next = '0;
        m_le_next   = 1'b0;
        m_te_next   = 1'b0;
        if (plan_reg.cr_le) begin
            m_le_next        = 1'b1;
            plan_after.cr_le = 1'b0;
        end else if (plan_reg.code_vld) begin
            m_code_next         = plan_reg.code_point;
            m_le_next           = plan_reg.code_le;
            plan_after.code_vld = 1'b0;
        end else if (plan_reg.space_cnt != '0) begin
            m_code_next          = utf8ls_pkg::CP_SPACE;
            plan_after.space_cnt = plan_reg.space_cnt - utf8ls_pkg::SPACE_W'(1);
        end else begin
            m_le_next      = 1'b1;
            m_te_next      = plan_reg.fin;
            plan_after.fin = 1'b0;
        end
        plan_last   = !(plan_after.cr_le || plan_after.code_vld ||
                        (plan_after.space_cnt != '0) || plan_after.fin);
        m_last_next = plan_last;
    end

    assign emit_en  = plan_any && (!m_tvalid_reg || m_tready);
    assign s_tready = !plan_any || (emit_en && plan_last);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        plan_next = plan_reg;
        if (s_accept) begin
            plan_next = plan_in;
        end else if (emit_en) begin
            plan_next = plan_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            plan_reg <= plan_next;
            if (emit_en) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_en) begin
            m_code_reg <= m_code_next;
            m_le_reg   <= m_le_next;
            m_te_reg   <= m_te_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_code_reg};
    assign m_tuser  = {m_te_reg, m_le_reg};
    assign m_tlast  = m_last_reg;

    `UTF8LS_ASSERT_NOW(a_te_is_le, m_tvalid && m_tuser[1], m_tuser[0] && m_tlast, "text end without line end or last")
    `UTF8LS_ASSERT_NOW(a_le_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0, "line end carries a code")
    `UTF8LS_ASSERT_NOW(a_no_overrun, plan_any && m_tvalid_reg && !m_tready, !s_tready, "input taken while results stalled")

endmodule
